// ===== hdl/fcp_pkg.sv =====
// Package for the framed command parser: parse phase codes, character
// constants and the command record passed from the parser core to the top.
// No dependencies.
package fcp_pkg;

  // Parse phase, one-hot coded.
  typedef enum logic [2:0] {
    PHASE_SEEK    = 3'b001,
    PHASE_TYPE    = 3'b010,
    PHASE_PAYLOAD = 3'b100
  } phase_e;

  // Fixed field widths of a command.
  localparam int unsigned TypeChars = 6;
  localparam int unsigned TypeWidth = 8 * TypeChars;
  localparam int unsigned TypeCntW  = 3;
  localparam int unsigned ValueW    = 16;

  // Longest type before the message is dropped.
  localparam logic [TypeCntW-1:0] MaxTypeChars = TypeCntW'(TypeChars);

  // Framing and sign characters.
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharZero   = 8'h30;

  // The threshold command type "PCTH", first character in the low byte.
  localparam logic [TypeCntW-1:0]  PcthLength = 3'd4;
  localparam logic [TypeWidth-1:0] PcthChars  = 48'h0000_4854_4350;

  // One parsed command.
  typedef struct packed {
    logic [TypeWidth-1:0]     type_chars;
    logic [TypeCntW-1:0]      type_length;
    logic signed [ValueW-1:0] first_value;
    logic signed [ValueW-1:0] second_value;
    logic                     is_threshold_command;
  } cmd_t;

endpackage

// ===== hdl/fcp_if.sv =====
// Channel interfaces of the framed command parser: the received byte stream
// and the parsed command stream, both with a valid/ready handshake.
// Depends on fcp_pkg for the field widths.
interface fcp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcp_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [fcp_pkg::TypeWidth-1:0]    type_chars;
  logic [fcp_pkg::TypeCntW-1:0]     type_length;
  logic signed [fcp_pkg::ValueW-1:0] first_value;
  logic signed [fcp_pkg::ValueW-1:0] second_value;
  logic                             is_threshold_command;

  modport source (output valid, output type_chars, output type_length, output first_value,
                  output second_value, output is_threshold_command, input ready);
  modport sink (input valid, input type_chars, input type_length, input first_value,
                input second_value, input is_threshold_command, output ready);
endinterface

// ===== hdl/framed_command_parser_top.sv =====
// Top level of the framed command parser: input byte register, parser core
// and command output register.
// Depends on fcp_pkg, fcp_rx_if, fcp_cmd_if and fcp_core.

// The parser takes one received byte per clock cycle unless stalled, and
// returns a command once the closing star of a sentence has been taken. The
// byte is registered, processed by the parser core when it moves on, and a
// finished command is held in an output register until it is taken; bytes
// keep flowing while that register is empty or being emptied, so the only
// thing that stalls the input is a command left waiting at the output.
// Bytes outside a sentence and bytes of an aborted sentence give no command.
module framed_command_parser_top #(
  parameter int unsigned MaxPayloadBytes = 100
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcp_rx_if.sink    rx_i,
  fcp_cmd_if.source cmd_o
);

  logic          byte_valid_q;
  logic [7:0]    byte_q;
  logic          advance;
  logic          emit;
  fcp_pkg::cmd_t cmd;
  logic          cmd_valid_q, cmd_valid_d;
  fcp_pkg::cmd_t cmd_q;

  // A held byte moves on whenever the output register has room.
  assign advance    = byte_valid_q && (!cmd_valid_q || cmd_o.ready);
  assign rx_i.ready = !byte_valid_q || advance;

  // Input byte register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      byte_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  fcp_core #(
    .MaxPayloadBytes(MaxPayloadBytes)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .emit_o (emit),
    .cmd_o  (cmd)
  );

  // Command output register.
  assign cmd_valid_d = emit || (cmd_valid_q && !cmd_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cmd_q <= cmd;
    end
  end

  assign cmd_o.valid                = cmd_valid_q;
  assign cmd_o.type_chars           = cmd_q.type_chars;
  assign cmd_o.type_length          = cmd_q.type_length;
  assign cmd_o.first_value          = cmd_q.first_value;
  assign cmd_o.second_value         = cmd_q.second_value;
  assign cmd_o.is_threshold_command = cmd_q.is_threshold_command;

endmodule

// ===== hdl/fcp_core.sv =====
// Parser core of the framed command parser: sentence state and on-the-fly
// decimal conversion, one byte per enabled cycle.
// Depends on fcp_pkg.
module fcp_core #(
  parameter int unsigned MaxPayloadBytes = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output logic          emit_o,
  output fcp_pkg::cmd_t cmd_o
);

  localparam int unsigned PcW = $clog2(MaxPayloadBytes + 1);
  localparam logic [PcW-1:0] PayloadLimit = PcW'(MaxPayloadBytes);

  fcp_pkg::phase_e                         phase_q, phase_d;
  logic [fcp_pkg::TypeChars-1:0][7:0]      type_q, type_d;
  logic [fcp_pkg::TypeCntW-1:0]            type_count_q, type_count_d;
  logic [PcW-1:0]                          payload_count_q, payload_count_d;
  logic [1:0]                              field_number_q, field_number_d;
  logic                                    at_start_q, at_start_d;
  logic                                    negative_q, negative_d;
  logic [fcp_pkg::ValueW-1:0]              acc_q, acc_d;
  logic [fcp_pkg::ValueW-1:0]              held_q, held_d;
  logic [fcp_pkg::ValueW-1:0]              field_value;
  logic [fcp_pkg::ValueW-1:0]              acc_next;
  logic                                    has_payload;

  // Current field value with its sign applied, and the next accumulator value.
  assign field_value = negative_q ? (~acc_q + 16'd1) : acc_q;
  assign acc_next    = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + {8'h00, byte_i}
                       - {8'h00, fcp_pkg::CharZero};

  // Next state for one received byte.
  always_comb begin
    phase_d         = phase_q;
    type_d          = type_q;
    type_count_d    = type_count_q;
    payload_count_d = payload_count_q;
    field_number_d  = field_number_q;
    at_start_d      = at_start_q;
    negative_d      = negative_q;
    acc_d           = acc_q;
    held_d          = held_q;
    emit_o          = 1'b0;
    if (step_i) begin
      case (phase_q)
        fcp_pkg::PHASE_TYPE: begin
          if (byte_i == fcp_pkg::CharComma) begin
            phase_d         = fcp_pkg::PHASE_PAYLOAD;
            payload_count_d = '0;
            field_number_d  = 2'd0;
            held_d          = '0;
            acc_d           = '0;
            negative_d      = 1'b0;
            at_start_d      = 1'b1;
          end else if (type_count_q >= fcp_pkg::MaxTypeChars) begin
            phase_d      = fcp_pkg::PHASE_SEEK;
            type_count_d = '0;
            type_d       = '0;
          end else if (byte_i == fcp_pkg::CharStar) begin
            emit_o  = 1'b1;
            phase_d = fcp_pkg::PHASE_SEEK;
          end else begin
            type_d[type_count_q] = byte_i;
            type_count_d         = type_count_q + 3'd1;
          end
        end
        fcp_pkg::PHASE_PAYLOAD: begin
          if (byte_i == fcp_pkg::CharStar) begin
            emit_o  = 1'b1;
            phase_d = fcp_pkg::PHASE_SEEK;
          end else if (payload_count_q >= PayloadLimit) begin
            phase_d         = fcp_pkg::PHASE_SEEK;
            payload_count_d = '0;
          end else begin
            payload_count_d = payload_count_q + PcW'(1);
            // Only the first two fields are converted.
            if (field_number_q != 2'd2) begin
              if (byte_i == fcp_pkg::CharComma) begin
                if (field_number_q == 2'd0) begin
                  held_d         = field_value;
                  field_number_d = 2'd1;
                  acc_d          = '0;
                  negative_d     = 1'b0;
                  at_start_d     = 1'b1;
                end else begin
                  field_number_d = 2'd2;
                end
              end else if (at_start_q &&
                           (byte_i inside {fcp_pkg::CharMinus, fcp_pkg::CharPlus})) begin
                negative_d = (byte_i == fcp_pkg::CharMinus);
                at_start_d = 1'b0;
              end else begin
                acc_d      = acc_next;
                at_start_d = 1'b0;
              end
            end
          end
        end
        default: begin
          // Seeking, and any code that is not a phase.
          if (byte_i == fcp_pkg::CharDollar) begin
            phase_d      = fcp_pkg::PHASE_TYPE;
            type_count_d = '0;
            type_d       = '0;
          end else begin
            phase_d = fcp_pkg::PHASE_SEEK;
          end
        end
      endcase
    end
  end

  // Command fields as they stand when the closing star arrives.
  assign has_payload = (phase_q == fcp_pkg::PHASE_PAYLOAD);
  always_comb begin
    cmd_o.type_chars   = type_q;
    cmd_o.type_length  = type_count_q;
    cmd_o.first_value  = '0;
    cmd_o.second_value = '0;
    if (has_payload) begin
      if (field_number_q == 2'd0) begin
        cmd_o.first_value = field_value;
      end else begin
        cmd_o.first_value  = held_q;
        cmd_o.second_value = field_value;
      end
    end
    cmd_o.is_threshold_command = (type_count_q == fcp_pkg::PcthLength) &&
                                 (type_q == fcp_pkg::PcthChars);
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= fcp_pkg::PHASE_SEEK;
      type_q          <= '0;
      type_count_q    <= '0;
      payload_count_q <= '0;
      field_number_q  <= 2'd0;
      at_start_q      <= 1'b1;
      negative_q      <= 1'b0;
      acc_q           <= '0;
      held_q          <= '0;
    end else begin
      phase_q         <= phase_d;
      type_q          <= type_d;
      type_count_q    <= type_count_d;
      payload_count_q <= payload_count_d;
      field_number_q  <= field_number_d;
      at_start_q      <= at_start_d;
      negative_q      <= negative_d;
      acc_q           <= acc_d;
      held_q          <= held_d;
    end
  end

`ifndef SYNTH
  // The type counter never passes the type limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    type_count_q <= fcp_pkg::MaxTypeChars)
    else $error("type count beyond limit");

  // The payload counter never passes the payload limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    payload_count_q <= PayloadLimit)
    else $error("payload count beyond limit");

  // A command only leaves from the type or payload phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> (phase_q == fcp_pkg::PHASE_TYPE || phase_q == fcp_pkg::PHASE_PAYLOAD))
    else $error("command emitted while seeking");

  // After a command the parser hunts for the next start marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |=> (phase_q == fcp_pkg::PHASE_SEEK))
    else $error("parser did not return to seeking after a command");
`endif

endmodule
